@@ hdl/psl_pkg.sv @@
// package for the positional sorted list engine
// holds command and status codes and the per-cell control struct; no dependencies
`default_nettype none

package psl_pkg;

   localparam int CMD_W    = 4;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_INS_SORTED = 4'd3;
   localparam logic [CMD_W-1:0] CMD_RD_FIRST   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_RD_LAST    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_RD_POS     = 4'd6;
   localparam logic [CMD_W-1:0] CMD_RM_FRONT   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_RM_BACK    = 4'd8;
   localparam logic [CMD_W-1:0] CMD_RM_POS     = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic load;
      logic take_left;
      logic take_right;
      logic select;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hdl/psl_if.sv @@
// request and response channel interfaces for the positional sorted list engine
// depends on psl_pkg for field widths
`default_nettype none

interface psl_req_if #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7
);
   logic                         valid;
   logic                         ready;
   logic [psl_pkg::CMD_W-1:0]    cmd;
   logic signed [DATA_WIDTH-1:0] item_value;
   logic [CNT_W-1:0]             slot;

   modport source (output valid, cmd, item_value, slot, input ready);
   modport sink   (input valid, cmd, item_value, slot, output ready);
endinterface

interface psl_rsp_if #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] read_value;
   logic [psl_pkg::STATUS_W-1:0] status;
   logic [CNT_W-1:0]             fill_count;

   modport source (output valid, read_value, status, fill_count, input ready);
   modport sink   (input valid, read_value, status, fill_count, output ready);
endinterface

`default_nettype wire

@@ hdl/psl_cell.sv @@
// one list cell: holds a word, shifts to/from its neighbors, compares against the key
// depends on psl_pkg for cell_ctl_type
`default_nettype none

module psl_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  wire                          clock,
   input  wire psl_pkg::cell_ctl_type   ctl,
   input  wire logic [DATA_WIDTH-1:0]   left_value,
   input  wire logic [DATA_WIDTH-1:0]   right_value,
   input  wire logic [DATA_WIDTH-1:0]   new_value,
   output logic      [DATA_WIDTH-1:0]   value,
   output logic                         greater,
   output logic      [DATA_WIDTH-1:0]   sel_value
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   always_comb begin
      if (ctl.load) begin
         value_in = new_value;
      end else if (ctl.take_left) begin
         value_in = left_value;
      end else if (ctl.take_right) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign greater   = $signed(value_ff) > $signed(new_value);
   assign sel_value = ctl.select ? value_ff : '0;

endmodule

`default_nettype wire

@@ hdl/positional_sorted_list_engine_unit.sv @@
// positional sorted list engine: a row of CAPACITY cells shifting in parallel
// response: the result of a request is registered as the request is taken
// throughput: one request per cycle while results are taken; a result that is
// still waiting stalls the next request until it is taken
// reset: synchronous, clears the count and the response valid flag; cell words stay undefined
// depends on psl_pkg, psl_if and psl_cell
`default_nettype none

module positional_sorted_list_engine_unit #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7
) (
   input  wire      clock,
   input  wire      reset,
   psl_req_if.sink   req,
   psl_rsp_if.source rsp
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]        read_value_ff, read_value_in;
   logic [psl_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [CNT_W-1:0]             count_ff, count_in;

   logic accept;
   logic is_ins, is_rd, is_rm;
   logic is_full, is_empty;
   logic do_insert, do_remove, do_read, use_sorted;
   logic [CNT_W-1:0] ins_pos, rm_pos;

   logic [DATA_WIDTH-1:0]   cell_value [CAPACITY];
   logic [DATA_WIDTH-1:0]   cell_sel   [CAPACITY];
   psl_pkg::cell_ctl_type   cell_ctl   [CAPACITY];
   logic [CAPACITY-1:0]     cell_gt;
   logic [CAPACITY-1:0]     gt_valid;
   logic [CAPACITY-1:0]     gt_after;
   logic [CAPACITY-1:0]     at_after;
   logic [DATA_WIDTH-1:0]   sel_or;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // command decode and checks
   always_comb begin
      is_ins     = req.cmd inside {[psl_pkg::CMD_INS_FRONT:psl_pkg::CMD_INS_SORTED]};
      is_rd      = req.cmd inside {[psl_pkg::CMD_RD_FIRST:psl_pkg::CMD_RD_POS]};
      is_rm      = req.cmd inside {[psl_pkg::CMD_RM_FRONT:psl_pkg::CMD_RM_POS]};
      is_full    = count_ff == FULL_COUNT;
      is_empty   = count_ff == '0;
      use_sorted = req.cmd == psl_pkg::CMD_INS_SORTED;
      status_in  = psl_pkg::ST_OK;

      case (req.cmd)
         psl_pkg::CMD_INS_FRONT: ins_pos = '0;
         psl_pkg::CMD_INS_BACK:  ins_pos = count_ff;
         default:                ins_pos = req.slot;
      endcase

      case (req.cmd)
         psl_pkg::CMD_RD_FIRST, psl_pkg::CMD_RM_FRONT: rm_pos = '0;
         psl_pkg::CMD_RD_LAST,  psl_pkg::CMD_RM_BACK:  rm_pos = count_ff - 1'b1;
         default:                                      rm_pos = req.slot;
      endcase

      if (is_ins) begin
         if (is_full) begin
            status_in = psl_pkg::ST_FULL;
         end else if (req.cmd == psl_pkg::CMD_INS_POS && req.slot > count_ff) begin
            status_in = psl_pkg::ST_RANGE;
         end
      end else if (is_rd || is_rm) begin
         if (is_empty) begin
            status_in = psl_pkg::ST_EMPTY;
         end else if ((req.cmd == psl_pkg::CMD_RD_POS || req.cmd == psl_pkg::CMD_RM_POS)
                      && req.slot >= count_ff) begin
            status_in = psl_pkg::ST_RANGE;
         end
      end

      do_insert = accept && is_ins && status_in == psl_pkg::ST_OK;
      do_remove = accept && is_rm && status_in == psl_pkg::ST_OK;
      do_read   = (is_rd || is_rm) && status_in == psl_pkg::ST_OK;
   end

   // or with its two's complement negation marks the first greater entry and everything after it
   assign gt_after = gt_valid | ((~gt_valid) + 1'b1);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic at_prev;

      assign gt_valid[i] = cell_gt[i] && (IDX < count_ff);
      assign at_after[i] = use_sorted ? (gt_after[i] || IDX >= count_ff) : (IDX >= ins_pos);

      if (i == 0) begin : g_first
         assign at_prev = 1'b0;
      end else begin : g_rest
         assign at_prev = at_after[i-1];
      end

      assign cell_ctl[i].load       = do_insert && at_after[i] && !at_prev;
      assign cell_ctl[i].take_left  = do_insert && at_after[i] && at_prev;
      assign cell_ctl[i].take_right = do_remove && IDX >= rm_pos;
      assign cell_ctl[i].select     = IDX == rm_pos;

      psl_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .left_value  ((i == 0) ? '0 : cell_value[(i == 0) ? 0 : i-1]),
         .right_value ((i == CAPACITY-1) ? '0 : cell_value[(i == CAPACITY-1) ? i : i+1]),
         .new_value   (req.item_value),
         .value       (cell_value[i]),
         .greater     (cell_gt[i]),
         .sel_value   (cell_sel[i])
      );
   end

   always_comb begin
      sel_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_or = sel_or | cell_sel[i];
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      read_value_in = read_value_ff;
      fill_in       = fill_ff;
      if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (do_remove) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         read_value_in = do_read ? sel_or : '0;
         fill_in       = count_in;
      end
   end

   logic [psl_pkg::STATUS_W-1:0] status_next;
   assign status_next = accept ? status_in : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_value_ff <= read_value_in;
      status_ff     <= status_next;
      fill_ff       <= fill_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = read_value_ff;
   assign rsp.status     = status_ff;
   assign rsp.fill_count = fill_ff;

endmodule

`default_nettype wire
